FILE: hw/rtl/lfdu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED frame difference updater package
// Shared codes, types and the board orientation map for the frame updater.
// ----------------------------------------------------------------------------
package lfdu_pkg;

    // Grid geometry: a 16x16 picture made from four 8x8 boards.
    localparam int GRID_SIZE = 16;
    localparam int ROW_W     = 4;
    localparam int COL_W     = 4;
    localparam int LEN_W     = 5;

    // Input item action codes.
    typedef enum logic [1:0] {
        ACT_WRITE_RUN = 2'd0,
        ACT_CLEAR     = 2'd1,
        ACT_UPDATE    = 2'd2
    } lfdu_action_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } lfdu_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;      // latch the row and restart the column scan
        logic write_run;  // apply a write run to the current frame
        logic clear;      // zero the current frame
        logic step;       // advance the scan column
        logic emit;       // send the LED write for the scan column
    } lfdu_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic diff_bit;      // scan pixel differs from the shown frame
        logic out_free;      // output register can take an item this cycle
        logic col_last;      // scan column is the final one
        logic row_diff_zero; // scanned row matches the shown frame
    } lfdu_status_t;

    // LED address on one board.
    typedef struct packed {
        logic [1:0] board;
        logic [2:0] led_row;
        logic [2:0] led_col;
    } led_addr_t;

    // Board index for each quadrant, by top/bottom half and then left/right.
    localparam logic [1:0] BOARD_OF_QUADRANT [2][2] = '{'{2'd2, 2'd1}, '{2'd3, 2'd0}};

    // Map a grid pixel to its board and the board's own row and column.
    function automatic led_addr_t map_led(input logic [ROW_W-1:0] row,
                                          input logic [COL_W-1:0] col);
        led_addr_t  a;
        logic       t;
        logic       l;
        logic [2:0] r;
        logic [2:0] c;
        t = row[3];
        l = col[3];
        r = row[2:0];
        c = col[2:0];
        a.board = BOARD_OF_QUADRANT[t][l];
        if (!t) begin
            if (!l) begin
                a.led_row = ~r;
                a.led_col = c + 3'd1;
            end else begin
                a.led_row = c;
                a.led_col = r + 3'd1;
            end
        end else begin
            if (!l) begin
                a.led_row = ~c;
                a.led_col = 3'd0 - r;
            end else begin
                a.led_row = r;
                a.led_col = 3'd0 - c;
            end
        end
        return a;
    endfunction

endpackage

FILE: hw/rtl/lfdu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED frame difference updater controller
// Accepts items, dispatches write and clear items, and sequences the
// sixteen-column scan of a row update.
// ----------------------------------------------------------------------------
module lfdu_ctrl
    import lfdu_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  lfdu_action_t action,
    input  lfdu_status_t status,
    output lfdu_cmd_t    cmd
);

    lfdu_state_t state_reg;
    lfdu_state_t state_next;
    logic        accept;
    logic        step_ok;

    assign accept  = s_tvalid && s_tready;
    // A column moves on when it needs no write or when its write can go out.
    assign step_ok = !status.diff_bit || status.out_free;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && action == ACT_UPDATE) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (step_ok && status.col_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs. In idle the block is always ready, so a valid item is taken.
    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (action)
                        ACT_WRITE_RUN: cmd.write_run = 1'b1;
                        ACT_CLEAR:     cmd.clear     = 1'b1;
                        ACT_UPDATE:    cmd.start     = 1'b1;
                        default:       cmd           = '0;
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.step = step_ok;
                cmd.emit = status.diff_bit && status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/lfdu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED frame difference updater datapath
// Holds the current and shown frames, the scan position and the output
// register that carries LED writes.
// ----------------------------------------------------------------------------
module lfdu_dp
    import lfdu_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  lfdu_cmd_t        cmd,
    input  logic [ROW_W-1:0] in_row,
    input  logic [COL_W-1:0] in_col,
    input  logic [LEN_W-1:0] in_run_length,
    input  logic             in_on,
    output lfdu_status_t     status,
    output logic             m_tvalid,
    input  logic             m_tready,
    output led_addr_t        out_addr,
    output logic             out_lit,
    output logic             out_last
);

    logic [GRID_SIZE-1:0] cur_frame_reg   [GRID_SIZE];
    logic [GRID_SIZE-1:0] shown_frame_reg [GRID_SIZE];
    logic [ROW_W-1:0]     row_reg;
    logic [COL_W-1:0]     col_reg;
    logic                 m_tvalid_reg;
    led_addr_t            addr_reg;
    logic                 lit_reg;
    logic                 last_reg;

    logic [GRID_SIZE-1:0] run_mask;
    logic [LEN_W:0]       run_end;
    logic [GRID_SIZE-1:0] cur_word;
    logic [GRID_SIZE-1:0] shown_word;
    logic [GRID_SIZE-1:0] diff_word;
    logic [GRID_SIZE-1:0] diff_rest;
    logic                 emit_last;

    // Columns touched by a write run; those past the edge fall away.
    assign run_end = {2'b00, in_col} + {1'b0, in_run_length};
    always_comb begin
        for (int c = 0; c < GRID_SIZE; c++) begin
            run_mask[c] = (6'(c) >= {2'b00, in_col}) && (6'(c) < run_end);
        end
    end

    // Scanned row and its pending differences.
    assign cur_word   = cur_frame_reg[row_reg];
    assign shown_word = shown_frame_reg[row_reg];
    assign diff_word  = cur_word ^ shown_word;
    assign diff_rest  = diff_word >> col_reg;
    // The write is the last one when no difference remains to its right.
    assign emit_last  = (diff_rest[GRID_SIZE-1:1] == '0);

    assign status.diff_bit      = diff_word[col_reg];
    assign status.out_free      = !m_tvalid_reg || m_tready;
    assign status.col_last      = (col_reg == COL_W'(GRID_SIZE - 1));
    assign status.row_diff_zero = (diff_word == '0);

    // Frame stores and scan position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < GRID_SIZE; i++) begin
                cur_frame_reg[i]   <= '0;
                shown_frame_reg[i] <= '0;
            end
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            if (cmd.clear) begin
                for (int i = 0; i < GRID_SIZE; i++) begin
                    cur_frame_reg[i] <= '0;
                end
            end else if (cmd.write_run) begin
                if (in_on) begin
                    cur_frame_reg[in_row] <= cur_frame_reg[in_row] | run_mask;
                end else begin
                    cur_frame_reg[in_row] <= cur_frame_reg[in_row] & ~run_mask;
                end
            end
            if (cmd.emit) begin
                shown_frame_reg[row_reg][col_reg] <= cur_word[col_reg];
            end
            if (cmd.start) begin
                row_reg <= in_row;
                col_reg <= '0;
            end else if (cmd.step) begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            addr_reg <= map_led(row_reg, col_reg);
            lit_reg  <= cur_word[col_reg];
            last_reg <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign out_addr = addr_reg;
    assign out_lit  = lit_reg;
    assign out_last = last_reg;

endmodule

FILE: hw/rtl/led_frame_diff_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED frame difference updater
// Composes a 16x16 one-bit picture and sends only changed pixels as LED
// writes to four 8x8 driver boards.
// ----------------------------------------------------------------------------
// A write-run or clear item produces no output. An update item is accepted
// and then the scanner steps through each of the sixteen columns in turn; a
// column whose LED write finds the output register still full waits there
// until the downstream side takes the previous item. The next item is
// accepted as soon as the scan of the row ends, even while its final LED
// write still waits at the output. Both frame stores are zero after reset,
// so the first update of a row sends only the pixels lit since then. The
// final LED write of an update carries m_tlast.
module led_frame_diff_update
    import lfdu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0], row[5:2], col[9:6], run_length[14:10], on[15]
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // board[1:0], led_row[4:2], led_col[7:5], lit[8], zero fill[15:9]
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    lfdu_cmd_t    cmd;
    lfdu_status_t status;
    led_addr_t    out_addr;
    logic         out_lit;
    logic         out_last;

    // Sequencing.
    lfdu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (lfdu_action_t'(s_tdata[1:0])),
        .status   (status),
        .cmd      (cmd)
    );

    // Frame stores, scan and output register.
    lfdu_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_row        (s_tdata[5:2]),
        .in_col        (s_tdata[9:6]),
        .in_run_length (s_tdata[14:10]),
        .in_on         (s_tdata[15]),
        .status        (status),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .out_addr      (out_addr),
        .out_lit       (out_lit),
        .out_last      (out_last)
    );

    assign m_tdata = {7'b0, out_lit, out_addr.led_col, out_addr.led_row, out_addr.board};
    assign m_tlast = out_last;

`ifndef SYNTHESIS
    // An LED write never overwrites an item the downstream side has not taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(m_tvalid && !m_tready))
        else $error("LED write issued while the output register was full");

    // After the final write of an update the scanned row matches the LEDs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (!m_tlast || status.row_diff_zero))
        else $error("Differences remain after the final LED write");

    // Finishing the last column returns the block to accepting items.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && status.col_last) |=> s_tready)
        else $error("Block did not return to idle after a row scan");
`endif

endmodule

FILE: sim/tb_led_frame_diff_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the LED frame difference updater
// Drives write-run, clear and row-update items into the block. A predictor
// keeps its own copy of the composed picture and of the picture that is shown
// on the boards. From these it works out the LED writes that each row update
// must send. Every LED write that comes out is checked field by field against
// the oldest write that is due. A directed part comes first, then random row
// sequences with random stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_led_frame_diff_update;
    import lfdu_pkg::*;

    // The one action code that the package leaves unnamed; the block ignores it.
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_AT_ITEM    = 60;
    localparam int TAIL_CYCLES     = 40;
    localparam int MAX_REPORTS     = 40;

    // One input item, in the same bit order as s_tdata.
    typedef struct packed {
        logic       on;
        logic [4:0] len;
        logic [3:0] col;
        logic [3:0] row;
        logic [1:0] act;
    } frame_item_t;

    // One LED write as it leaves the block.
    typedef struct packed {
        logic [1:0] board;
        logic [2:0] led_row;
        logic [2:0] led_col;
        logic       lit;
        logic       last;
    } led_write_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // Predictor state: the picture being composed and the one on the boards.
    logic [15:0] picture [GRID_SIZE];
    logic [15:0] shown   [GRID_SIZE];

    frame_item_t pending_items [$];
    led_write_t  writes_due    [$];
    frame_item_t offered;

    int src_idle_pct = 0;
    int rx_idle_pct  = 0;
    int src_wait     = 0;
    int rx_wait      = 0;
    int hold_cnt     = 0;
    bit hold_done    = 1'b0;
    int items_in     = 0;
    int err_cnt      = 0;
    int quiet_cycles = 0;

    led_frame_diff_update i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Idle cycles before the next item on one side, given the share of items
    // that idle at all.
    function automatic int draw_gap(input int pct);
        if ($urandom_range(0, 99) < pct) begin
            return $urandom_range(0, 17);
        end
        return 0;
    endfunction

    // Board address of a grid pixel after the fixed orientation of the boards.
    function automatic led_write_t board_address(input logic [3:0] row,
                                                 input logic [3:0] col);
        led_write_t w;
        int         r;
        int         c;
        r = row[2:0];
        c = col[2:0];
        w = '0;
        case ({row[3], col[3]})
            2'b00: begin
                w.board   = 2'd2;
                w.led_row = 3'(7 - r);
                w.led_col = 3'((c + 1) % 8);
            end
            2'b01: begin
                w.board   = 2'd1;
                w.led_row = 3'(c);
                w.led_col = 3'((r + 1) % 8);
            end
            2'b10: begin
                w.board   = 2'd3;
                w.led_row = 3'(7 - c);
                w.led_col = 3'((8 - r) % 8);
            end
            default: begin
                w.board   = 2'd0;
                w.led_row = 3'(r);
                w.led_col = 3'((8 - c) % 8);
            end
        endcase
        return w;
    endfunction

    // Apply one accepted item to the predicted pictures and queue the LED
    // writes that a row update sends.
    function automatic void compose_frame(input frame_item_t it);
        led_write_t  w;
        logic [15:0] diff;
        int          last_col;
        diff     = '0;
        last_col = -1;
        case (it.act)
            ACT_WRITE_RUN: begin
                // Columns beyond the right edge are dropped, never wrapped.
                for (int i = 0; i < it.len; i++) begin
                    if (it.col + i < GRID_SIZE) begin
                        picture[it.row][it.col + i] = it.on;
                    end
                end
            end
            ACT_CLEAR: begin
                for (int k = 0; k < GRID_SIZE; k++) begin
                    picture[k] = '0;
                end
            end
            ACT_UPDATE: begin
                diff = picture[it.row] ^ shown[it.row];
                for (int c = 0; c < GRID_SIZE; c++) begin
                    if (diff[c]) begin
                        last_col = c;
                    end
                end
                for (int c = 0; c < GRID_SIZE; c++) begin
                    if (diff[c]) begin
                        shown[it.row][c] = picture[it.row][c];
                        w      = board_address(it.row, 4'(c));
                        w.lit  = picture[it.row][c];
                        w.last = (c == last_col);
                        writes_due.push_back(w);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void queue_item(input logic [1:0] act, input logic [3:0] row,
                                       input logic [3:0] col, input logic [4:0] len,
                                       input logic on);
        frame_item_t it;
        it.act = act;
        it.row = row;
        it.col = col;
        it.len = len;
        it.on  = on;
        pending_items.push_back(it);
    endfunction

    // Run lengths favor short runs, with empty and full-width runs mixed in.
    function automatic logic [4:0] draw_run();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            return 5'd0;
        end
        if (pick < 18) begin
            return 5'd16;
        end
        if (pick < 30) begin
            return 5'($urandom_range(7, 15));
        end
        return 5'($urandom_range(1, 6));
    endfunction

    // Random stimulus: mostly writes to a row followed by an update of that
    // row, with stray writes, stray updates, clears, full refreshes and ignored codes.
    task automatic queue_random(input int count);
        int         made;
        int         kind;
        int         writes;
        logic [3:0] r;
        made = 0;
        while (made < count) begin
            kind = $urandom_range(0, 99);
            r    = 4'($urandom_range(0, 15));
            if (kind < 65) begin
                writes = $urandom_range(1, 3);
                for (int i = 0; i < writes; i++) begin
                    queue_item(ACT_WRITE_RUN, r, 4'($urandom_range(0, 15)), draw_run(),
                               1'($urandom_range(0, 1)));
                end
                queue_item(ACT_UPDATE, r, 4'($urandom_range(0, 15)),
                           5'($urandom_range(0, 16)), 1'($urandom_range(0, 1)));
                made += writes + 1;
            end else if (kind < 77) begin
                queue_item(ACT_WRITE_RUN, r, 4'($urandom_range(0, 15)), draw_run(),
                           1'($urandom_range(0, 1)));
                made++;
            end else if (kind < 81) begin
                queue_item(ACT_CLEAR, r, 4'($urandom_range(0, 15)),
                           5'($urandom_range(0, 16)), 1'($urandom_range(0, 1)));
                made++;
            end else if (kind < 85) begin
                for (int k = 0; k < GRID_SIZE; k++) begin
                    queue_item(ACT_UPDATE, 4'(k), 4'd0, 5'd0, 1'b0);
                end
                made += GRID_SIZE;
            end else if (kind < 95) begin
                queue_item(ACT_UPDATE, r, 4'($urandom_range(0, 15)),
                           5'($urandom_range(0, 16)), 1'($urandom_range(0, 1)));
                made++;
            end else begin
                queue_item(ACT_IGNORED, r, 4'($urandom_range(0, 15)),
                           5'($urandom_range(0, 16)), 1'($urandom_range(0, 1)));
                made++;
            end
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        end
    endfunction

    // Driver: offer items from the pending queue, with a random gap after each.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_wait = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                compose_frame(offered);
                items_in <= items_in + 1;
                src_wait = draw_gap(src_idle_pct);
            end
            if (src_wait > 0) begin
                src_wait--;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                offered = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= offered;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each LED write and pace m_tready, including one long hold.
    always @(posedge aclk) begin
        led_write_t got;
        led_write_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  = 0;
            hold_cnt = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.board   = m_tdata[1:0];
                got.led_row = m_tdata[4:2];
                got.led_col = m_tdata[7:5];
                got.lit     = m_tdata[8];
                got.last    = m_tlast;
                if (writes_due.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS) begin
                        $display("%0t: LED write, expected none, actual board %0d row %0d col %0d",
                                 $time, got.board, got.led_row, got.led_col);
                    end
                end else begin
                    want = writes_due.pop_front();
                    check_field("board", want.board, got.board);
                    check_field("led_row", want.led_row, got.led_row);
                    check_field("led_col", want.led_col, got.led_col);
                    check_field("lit", want.lit, got.lit);
                    check_field("last", want.last, got.last);
                end
                rx_wait = draw_gap(rx_idle_pct);
            end
            if (!hold_done && items_in >= HOLD_AT_ITEM) begin
                hold_done = 1'b1;
                hold_cnt  = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any item moving on either side ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || writes_due.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Stimulus sequence.
    initial begin
        for (int k = 0; k < GRID_SIZE; k++) begin
            picture[k] = '0;
            shown[k]   = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part with light idling on both sides.
        src_idle_pct = 30;
        rx_idle_pct  = 30;
        queue_item(ACT_UPDATE,    4'd0,  4'd0,  5'd0,  1'b0); // nothing changed yet
        queue_item(ACT_WRITE_RUN, 4'd0,  4'd0,  5'd16, 1'b1);
        queue_item(ACT_UPDATE,    4'd0,  4'd0,  5'd0,  1'b0); // a full row of writes
        queue_item(ACT_WRITE_RUN, 4'd15, 4'd15, 5'd16, 1'b1); // run past the right edge
        queue_item(ACT_WRITE_RUN, 4'd15, 4'd8,  5'd0,  1'b1); // empty run
        queue_item(ACT_UPDATE,    4'd15, 4'd15, 5'd16, 1'b1);
        queue_item(ACT_WRITE_RUN, 4'd7,  4'd7,  5'd2,  1'b1); // across the quadrant seam
        queue_item(ACT_WRITE_RUN, 4'd8,  4'd7,  5'd2,  1'b1);
        queue_item(ACT_UPDATE,    4'd7,  4'd0,  5'd0,  1'b0);
        queue_item(ACT_UPDATE,    4'd8,  4'd0,  5'd0,  1'b0);
        queue_item(ACT_IGNORED,   4'd15, 4'd15, 5'd16, 1'b1); // unused code
        queue_item(ACT_UPDATE,    4'd3,  4'd0,  5'd0,  1'b0); // row unchanged
        queue_item(ACT_CLEAR,     4'd0,  4'd0,  5'd0,  1'b0);
        queue_item(ACT_UPDATE,    4'd0,  4'd0,  5'd0,  1'b0); // a full row turned off
        queue_item(ACT_UPDATE,    4'd15, 4'd0,  5'd0,  1'b0);
        queue_item(ACT_WRITE_RUN, 4'd0,  4'd5,  5'd1,  1'b0); // clear an unlit pixel
        queue_item(ACT_UPDATE,    4'd0,  4'd0,  5'd0,  1'b0);
        queue_item(ACT_WRITE_RUN, 4'd9,  4'd12, 5'd3,  1'b1);
        queue_item(ACT_WRITE_RUN, 4'd9,  4'd13, 5'd1,  1'b0);
        queue_item(ACT_UPDATE,    4'd9,  4'd0,  5'd0,  1'b0);
        queue_item(ACT_WRITE_RUN, 4'd4,  4'd0,  5'd16, 1'b1);
        queue_item(ACT_UPDATE,    4'd4,  4'd0,  5'd0,  1'b0);
        queue_item(ACT_CLEAR,     4'd0,  4'd0,  5'd0,  1'b0);
        queue_item(ACT_WRITE_RUN, 4'd4,  4'd3,  5'd1,  1'b1);
        queue_item(ACT_UPDATE,    4'd4,  4'd0,  5'd0,  1'b0);
        wait_drained();

        // Full rate on both sides; the long output hold-off falls in here.
        src_idle_pct = 0;
        rx_idle_pct  = 0;
        queue_random(105);
        wait_drained();

        // Mixed idling.
        src_idle_pct = 50;
        rx_idle_pct  = 40;
        queue_random(100);
        wait_drained();

        // Every item draws a random idle gap on both sides, which may be zero.
        src_idle_pct = 100;
        rx_idle_pct  = 100;
        queue_random(100);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
